>>> design/remote_control_frame_decoder_assert.svh
// Assertion macros shared by the remote-control frame decoder RTL.
`ifndef REMOTE_CONTROL_FRAME_DECODER_ASSERT_SVH
`define REMOTE_CONTROL_FRAME_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever cond holds, prop must hold too.
`define RCFD_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rcfd assertion failed");

// Next-cycle implication: whenever cond holds, prop must hold in the following cycle.
`define RCFD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rcfd assertion failed");

`else

`define RCFD_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define RCFD_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

>>> design/rcfd_pkg.sv
// Types and constants shared by the remote-control frame decoder modules.
package rcfd_pkg;

    localparam int unsigned FRAME_PART_W = 48;
    localparam int unsigned STICK_W      = 11;
    localparam int unsigned DEADBAND_W   = 10;
    localparam int unsigned LIMIT_W      = 11;
    localparam int unsigned SW_W         = 2;
    localparam int unsigned SW_FLAGS_W   = 7;
    localparam int unsigned WORD_W       = 16;

    // Configuration register indexes.
    localparam logic CFG_DEADBAND    = 1'b0;
    localparam logic CFG_STICK_LIMIT = 1'b1;

    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET    = 10'd5;
    localparam logic [LIMIT_W-1:0]    STICK_LIMIT_RESET = 11'd660;

    // Offset removed from the wheel word.
    localparam logic [WORD_W-1:0] WHEEL_CENTER = 16'd1024;

    // Switch position codes.
    localparam logic [SW_W-1:0] SW_NONE = 2'd0;
    localparam logic [SW_W-1:0] SW_UP   = 2'd1;
    localparam logic [SW_W-1:0] SW_DOWN = 2'd2;
    localparam logic [SW_W-1:0] SW_MID  = 2'd3;

    // Bit positions inside one switch's flag group.
    localparam int unsigned FLAG_UP       = 0;
    localparam int unsigned FLAG_MID      = 1;
    localparam int unsigned FLAG_DOWN     = 2;
    localparam int unsigned FLAG_UP2MID   = 3;
    localparam int unsigned FLAG_DOWN2MID = 4;
    localparam int unsigned FLAG_MID2UP   = 5;
    localparam int unsigned FLAG_MID2DOWN = 6;

    typedef struct packed {
        logic [DEADBAND_W-1:0] deadband;
        logic [LIMIT_W-1:0]    stick_limit;
    } rcfd_cfg_t;

    typedef struct packed {
        logic signed [STICK_W-1:0]   stick_one;
        logic signed [STICK_W-1:0]   stick_two;
        logic signed [STICK_W-1:0]   stick_three;
        logic signed [STICK_W-1:0]   stick_four;
        logic [2*SW_W-1:0]           switch_positions;
        logic [2*SW_FLAGS_W-1:0]     switch_flags;
        logic signed [WORD_W-1:0]    mouse_x;
        logic signed [WORD_W-1:0]    mouse_y;
        logic signed [WORD_W-1:0]    mouse_z;
        logic [WORD_W-1:0]           mouse_buttons;
        logic [WORD_W-1:0]           key_bitmap;
        logic signed [WORD_W-1:0]    wheel;
    } rcfd_result_t;

endpackage

>>> design/rcfd_chan.sv
// One stick channel: centering, deadband and over-limit detection.
module rcfd_chan (
    input  logic [rcfd_pkg::STICK_W-1:0]        raw,
    input  rcfd_pkg::rcfd_cfg_t                 cfg,
    output logic signed [rcfd_pkg::STICK_W-1:0] value,
    output logic                                over
);
    import rcfd_pkg::*;

    logic [STICK_W-1:0] centred;
    logic [STICK_W-1:0] mag;
    logic               in_band;

    // Subtracting the center of 1024 from an 11-bit code only flips the top bit.
    assign centred = {~raw[STICK_W-1], raw[STICK_W-2:0]};
    // The magnitude of the most negative value, 1024, still fits in 11 bits.
    assign mag     = centred[STICK_W-1] ? (~centred + STICK_W'(1)) : centred;
    assign in_band = (mag <= {1'b0, cfg.deadband});
    assign value   = in_band ? '0 : $signed(centred);
    assign over    = !in_band && (mag > cfg.stick_limit);

endmodule

>>> design/rcfd_swflags.sv
// Position and transition flags of one switch.
module rcfd_swflags (
    input  logic [rcfd_pkg::SW_W-1:0]       now_pos,
    input  logic [rcfd_pkg::SW_W-1:0]       prev_pos,
    output logic [rcfd_pkg::SW_FLAGS_W-1:0] flags
);
    import rcfd_pkg::*;

    always_comb
    begin
        flags = '0;
        unique case (now_pos)
            SW_MID:
            begin
                flags[FLAG_MID]      = 1'b1;
                flags[FLAG_UP2MID]   = (prev_pos == SW_UP);
                flags[FLAG_DOWN2MID] = (prev_pos == SW_DOWN);
            end
            SW_UP:
            begin
                flags[FLAG_UP]     = 1'b1;
                flags[FLAG_MID2UP] = (prev_pos == SW_MID);
            end
            SW_DOWN:
            begin
                flags[FLAG_DOWN]     = 1'b1;
                flags[FLAG_MID2DOWN] = (prev_pos == SW_MID);
            end
            default:
            begin
                flags = '0;
            end
        endcase
    end

endmodule

>>> design/rcfd_decode.sv
// Unpacks one registered frame into a result item.
module rcfd_decode (
    input  logic [rcfd_pkg::FRAME_PART_W-1:0] bytes_low,
    input  logic [rcfd_pkg::FRAME_PART_W-1:0] bytes_mid,
    input  logic [rcfd_pkg::FRAME_PART_W-1:0] bytes_high,
    input  rcfd_pkg::rcfd_cfg_t               cfg,
    input  logic [2*rcfd_pkg::SW_W-1:0]       prev_positions,
    output rcfd_pkg::rcfd_result_t            result
);
    import rcfd_pkg::*;

    logic signed [STICK_W-1:0] ch_one;
    logic signed [STICK_W-1:0] ch_two;
    logic signed [STICK_W-1:0] ch_three;
    logic signed [STICK_W-1:0] ch_four;
    logic [3:0]                over;
    logic                      invalid;
    logic [SW_W-1:0]           sw_one;
    logic [SW_W-1:0]           sw_two;
    logic [SW_FLAGS_W-1:0]     flags_one;
    logic [SW_FLAGS_W-1:0]     flags_two;

    // The four channels are packed back to back in the first 44 frame bits.
    rcfd_chan u_chan_one (
        .raw   (bytes_low[10:0]),
        .cfg   (cfg),
        .value (ch_one),
        .over  (over[0])
    );

    rcfd_chan u_chan_two (
        .raw   (bytes_low[21:11]),
        .cfg   (cfg),
        .value (ch_two),
        .over  (over[1])
    );

    rcfd_chan u_chan_three (
        .raw   (bytes_low[32:22]),
        .cfg   (cfg),
        .value (ch_three),
        .over  (over[2])
    );

    rcfd_chan u_chan_four (
        .raw   (bytes_low[43:33]),
        .cfg   (cfg),
        .value (ch_four),
        .over  (over[3])
    );

    assign sw_one = bytes_low[47:46];
    assign sw_two = bytes_low[45:44];

    rcfd_swflags u_sw_one (
        .now_pos  (sw_one),
        .prev_pos (prev_positions[3:2]),
        .flags    (flags_one)
    );

    rcfd_swflags u_sw_two (
        .now_pos  (sw_two),
        .prev_pos (prev_positions[1:0]),
        .flags    (flags_two)
    );

    assign invalid = |over;

    always_comb
    begin
        result.stick_one        = invalid ? '0 : ch_one;
        result.stick_two        = invalid ? '0 : ch_two;
        result.stick_three      = invalid ? '0 : ch_three;
        result.stick_four       = invalid ? '0 : ch_four;
        result.switch_positions = invalid ? '0 : {sw_one, sw_two};
        result.switch_flags     = invalid ? '0 : {flags_two, flags_one};
        result.mouse_x          = $signed(bytes_mid[15:0]);
        result.mouse_y          = $signed(bytes_mid[31:16]);
        result.mouse_z          = $signed(bytes_mid[47:32]);
        result.mouse_buttons    = bytes_high[15:0];
        result.key_bitmap       = bytes_high[31:16];
        result.wheel            = $signed(bytes_high[47:32] - WHEEL_CENTER);
    end

endmodule

>>> design/remote_control_frame_decoder.sv
// Top level of the remote-control frame decoder: registers, handshake and state.
//
//   Channel  Direction  Width  Contents
//   s_*      in         144    one 18-byte frame per item
//   m_*      out        160    decoded sticks, switches, flags, mouse, keys, wheel
//   cfg_*    in         1+11   deadband and stick limit writes
//
// An item is registered in the frame register on acceptance, decoded there and
// lands in the result register once that register is free or being taken.
// One item per cycle is sustained while m_tready holds: the decode logic between
// the frame register and the result register is the only work stage.
// Both stages stall together when the result register is full and not taken;
// an empty frame register still accepts an item while the result waits.
// Reset clears the valid flags, the configuration to its defaults and the
// remembered switch positions; there is no clearing pass.
module remote_control_frame_decoder (
    input  logic           clk,
    input  logic           rst_n,
    // Frame input.
    input  logic           s_tvalid,
    output logic           s_tready,
    // s_tdata: [47:0] frame_bytes_low, [95:48] frame_bytes_mid,
    //          [143:96] frame_bytes_high
    input  logic [143:0]   s_tdata,
    // Decoded output.
    output logic           m_tvalid,
    input  logic           m_tready,
    // m_tdata: [10:0] stick_one, [21:11] stick_two, [32:22] stick_three,
    //          [43:33] stick_four, [47:44] switch_positions, [61:48] switch_flags,
    //          [77:62] mouse_x, [93:78] mouse_y, [109:94] mouse_z,
    //          [125:110] mouse_buttons, [141:126] key_bitmap, [157:142] wheel,
    //          [159:158] zero
    output logic [159:0]   m_tdata,
    // Configuration writes.
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [10:0]    cfg_data
);
    import rcfd_pkg::*;

    `include "remote_control_frame_decoder_assert.svh"

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [3*FRAME_PART_W-1:0] frame_reg;
    logic                      res_valid_reg;
    logic                      res_valid_next;
    rcfd_result_t              res_reg;
    rcfd_result_t              res_next;
    rcfd_cfg_t                 cfg_reg;
    rcfd_cfg_t                 cfg_next;
    logic [2*SW_W-1:0]         prev_sw_reg;
    logic [2*SW_W-1:0]         prev_sw_next;
    logic                      advance;
    logic                      s_accept;
    logic                      full_stall;
    logic                      prev_matches;
    logic                      no_switch;
    logic                      flags_clear;

    // The whole pipeline moves when the result register is free or being taken.
    assign advance  = !res_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    rcfd_decode u_decode (
        .bytes_low      (frame_reg[FRAME_PART_W-1:0]),
        .bytes_mid      (frame_reg[2*FRAME_PART_W-1:FRAME_PART_W]),
        .bytes_high     (frame_reg[3*FRAME_PART_W-1:2*FRAME_PART_W]),
        .cfg            (cfg_reg),
        .prev_positions (prev_sw_reg),
        .result         (res_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        prev_sw_next   = prev_sw_reg;
        if (advance)
        begin
            res_valid_next = in_valid_reg;
            // The remembered positions follow each frame as it is reported;
            // an invalid frame reports, and so remembers, zero.
            if (in_valid_reg)
            begin
                prev_sw_next = res_next.switch_positions;
            end
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEADBAND:    cfg_next.deadband    = cfg_data[DEADBAND_W-1:0];
                CFG_STICK_LIMIT: cfg_next.stick_limit = cfg_data[LIMIT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            res_valid_reg        <= 1'b0;
            prev_sw_reg          <= '0;
            cfg_reg.deadband     <= DEADBAND_RESET;
            cfg_reg.stick_limit  <= STICK_LIMIT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            prev_sw_reg   <= prev_sw_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            frame_reg <= s_tdata;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {2'b00,
                       res_reg.wheel,
                       res_reg.key_bitmap,
                       res_reg.mouse_buttons,
                       res_reg.mouse_z,
                       res_reg.mouse_y,
                       res_reg.mouse_x,
                       res_reg.switch_flags,
                       res_reg.switch_positions,
                       res_reg.stick_four,
                       res_reg.stick_three,
                       res_reg.stick_two,
                       res_reg.stick_one};

    // Terms used by the checks below.
    assign full_stall   = in_valid_reg && res_valid_reg && !m_tready;
    assign prev_matches = (prev_sw_reg == res_reg.switch_positions);
    assign no_switch    = res_valid_reg && (res_reg.switch_positions == '0);
    assign flags_clear  = (res_reg.switch_flags == '0);

    // A full pipeline whose result is not taken must refuse new frames.
    `RCFD_ASSERT_IMPLIES(a_full_stall, clk, rst_n, full_stall, !s_tready)
    // The remembered switch positions always match the result on display.
    `RCFD_ASSERT_IMPLIES(a_prev_tracks, clk, rst_n, res_valid_reg, prev_matches)
    // No flag is raised when both switches are reported as absent, as for an invalid frame.
    `RCFD_ASSERT_IMPLIES(a_flags_need_pos, clk, rst_n, no_switch, flags_clear)
    // A decoded frame in flight reaches the result register once it moves.
    `RCFD_ASSERT_NEXT(a_frame_lands, clk, rst_n, in_valid_reg && advance, res_valid_reg)

endmodule

>>> sim/remote_control_frame_decoder_tb.sv
// Self-checking testbench for the remote-control frame decoder: directed, then random frames.
module remote_control_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcfd_pkg::*;

    // Raw stick value that decodes to zero.
    localparam int CENTER        = 1024;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 120;
    // Idle wait after the last result, so that the block can settle.
    localparam int SETTLE_CYCLES = 3;
    localparam int MAX_REPORTS   = 10;
    // Limit on the length of the whole run, in nanoseconds.
    localparam longint TIMEOUT_NS = 10_000_000;

    // One decoded frame, laid out exactly as m_tdata with stick_one in the lowest bits.
    typedef struct packed {
        logic [1:0]                pad;
        logic [WORD_W-1:0]         wheel;
        logic [WORD_W-1:0]         key_bitmap;
        logic [WORD_W-1:0]         mouse_buttons;
        logic [WORD_W-1:0]         mouse_z;
        logic [WORD_W-1:0]         mouse_y;
        logic [WORD_W-1:0]         mouse_x;
        logic [2*SW_FLAGS_W-1:0]   switch_flags;
        logic [2*SW_W-1:0]         switch_positions;
        logic signed [STICK_W-1:0] stick_four;
        logic signed [STICK_W-1:0] stick_three;
        logic signed [STICK_W-1:0] stick_two;
        logic signed [STICK_W-1:0] stick_one;
    } decoded_t;

    // A row of the directed table. When typed is set, want holds the result written out by
    // hand, and that result is checked in place of the prediction.
    typedef struct {
        logic [143:0] frame;
        bit           typed;
        decoded_t     want;
    } stim_row_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    // s_tdata: [47:0] frame_bytes_low, [95:48] frame_bytes_mid, [143:96] frame_bytes_high
    logic [143:0] s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // m_tdata: [10:0] stick_one, [21:11] stick_two, [32:22] stick_three, [43:33] stick_four,
    //          [47:44] switch_positions, [61:48] switch_flags, [77:62] mouse_x,
    //          [93:78] mouse_y, [109:94] mouse_z, [125:110] mouse_buttons,
    //          [141:126] key_bitmap, [157:142] wheel, [159:158] zero
    logic [159:0] m_tdata;
    logic         cfg_we    = 1'b0;
    logic         cfg_index = CFG_DEADBAND;
    logic [10:0]  cfg_data  = '0;

    // The testbench's own copy of the decoder: its configuration and the switch positions
    // it remembers from the previous frame.
    rcfd_cfg_t       model_cfg;
    logic [SW_W-1:0] last_sw_one;
    logic [SW_W-1:0] last_sw_two;

    // Decoded frames that have been predicted and are waiting for the block's output.
    decoded_t  pending_decodes[$];
    stim_row_t directed_rows[$];

    int unsigned mismatches     = 0;
    int unsigned results_seen   = 0;
    int unsigned frames_sent    = 0;
    int unsigned invalid_frames = 0;
    int unsigned transitions    = 0;
    int unsigned cfg_writes     = 0;
    int          send_burst     = 0;
    int          recv_burst     = 0;

    remote_control_frame_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Assembles a frame from its fields. The four 11-bit channels fill bits 43:0. The second
    // switch sits in bits 45:44 and the first in bits 47:46. Each 16-bit word that follows
    // is little endian.
    function automatic logic [143:0] make_frame(
        input logic [10:0] c0, input logic [10:0] c1,
        input logic [10:0] c2, input logic [10:0] c3,
        input logic [SW_W-1:0] sw_one, input logic [SW_W-1:0] sw_two,
        input logic [15:0] mx, input logic [15:0] my, input logic [15:0] mz,
        input logic [15:0] buttons, input logic [15:0] keys, input logic [15:0] wheel_raw);
        return {wheel_raw, keys, buttons, mz, my, mx, sw_one, sw_two, c3, c2, c1, c0};
    endfunction

    // Position and transition flags for one switch, given its current and previous code.
    function automatic logic [SW_FLAGS_W-1:0] switch_flags_for(
        input logic [SW_W-1:0] now_pos, input logic [SW_W-1:0] last_pos);
        logic [SW_FLAGS_W-1:0] f;
        f = '0;
        case (now_pos)
            SW_MID:
            begin
                f[FLAG_MID] = 1'b1;
                if (last_pos == SW_UP)
                    f[FLAG_UP2MID] = 1'b1;
                else if (last_pos == SW_DOWN)
                    f[FLAG_DOWN2MID] = 1'b1;
            end
            SW_UP:
            begin
                f[FLAG_UP] = 1'b1;
                if (last_pos == SW_MID)
                    f[FLAG_MID2UP] = 1'b1;
            end
            SW_DOWN:
            begin
                f[FLAG_DOWN] = 1'b1;
                if (last_pos == SW_MID)
                    f[FLAG_MID2DOWN] = 1'b1;
            end
            default:
            begin
                f = '0;
            end
        endcase
        return f;
    endfunction

    // Predicts the decoded result of one accepted frame and advances the remembered switch
    // positions. The deadband is applied before the limit test, so a channel that falls
    // inside the deadband can never make a frame invalid.
    function automatic decoded_t decode_frame(input logic [143:0] frame);
        decoded_t                  d;
        logic signed [STICK_W-1:0] ch [4];
        logic [SW_W-1:0]           sw_one;
        logic [SW_W-1:0]           sw_two;
        logic                      over;
        int                        c;
        int                        mag;
        d = '0;
        over = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            c = int'(frame[i*STICK_W +: STICK_W]) - CENTER;
            mag = (c < 0) ? -c : c;
            if (mag <= int'(model_cfg.deadband))
                c = 0;
            else if (mag > int'(model_cfg.stick_limit))
                over = 1'b1;
            ch[i] = STICK_W'(c);
        end
        sw_one = frame[47:46];
        sw_two = frame[45:44];
        if (over)
        begin
            // An invalid frame clears the sticks, the switches and the flags. It also
            // forgets the previous switch positions.
            foreach (ch[i])
                ch[i] = '0;
            sw_one = SW_NONE;
            sw_two = SW_NONE;
            invalid_frames++;
        end
        else
        begin
            d.switch_flags = {switch_flags_for(sw_two, last_sw_two),
                              switch_flags_for(sw_one, last_sw_one)};
        end
        if (d.switch_flags[FLAG_MID2DOWN:FLAG_UP2MID] != '0)
            transitions++;
        if (d.switch_flags[SW_FLAGS_W+FLAG_MID2DOWN:SW_FLAGS_W+FLAG_UP2MID] != '0)
            transitions++;
        last_sw_one = sw_one;
        last_sw_two = sw_two;
        d.stick_one        = ch[0];
        d.stick_two        = ch[1];
        d.stick_three      = ch[2];
        d.stick_four       = ch[3];
        d.switch_positions = {sw_one, sw_two};
        d.mouse_x          = frame[63:48];
        d.mouse_y          = frame[79:64];
        d.mouse_z          = frame[95:80];
        d.mouse_buttons    = frame[111:96];
        d.key_bitmap       = frame[127:112];
        d.wheel            = frame[143:128] - WHEEL_CENTER;
        return d;
    endfunction

    // Idle length for either side. Most gaps are short and a few are long. Now and then a
    // burst starts, during which the side does not idle at all.
    function automatic int idle_len(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Channel values are drawn around the current deadband and limit, so that both edges
    // are exercised. A small share is fully random, which may make the frame invalid.
    function automatic logic [10:0] rand_channel();
        int r;
        int span;
        int mag;
        int c;
        r = $urandom_range(0, 99);
        if (r >= 92)
            return 11'($urandom);
        span = (r < 25) ? int'(model_cfg.deadband) + 2 : int'(model_cfg.stick_limit) + 1;
        if (span > CENTER)
            span = CENTER;
        mag = $urandom_range(0, span);
        c = $urandom_range(0, 1) ? CENTER + mag : CENTER - mag;
        if (c > 2047)
            c = 2047;
        return 11'(c);
    endfunction

    // Switch codes lean toward mid. Every transition passes through mid, so this raises
    // transition flags often.
    function automatic logic [SW_W-1:0] rand_switch();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)
            return SW_UP;
        if (r < 8)
            return SW_DOWN;
        if (r < 17)
            return SW_MID;
        return SW_W'($urandom);
    endfunction

    function automatic logic [143:0] rand_frame();
        // Pure noise now and then. The rest are frames with plausible fields.
        if ($urandom_range(0, 99) < 5)
            return {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        return make_frame(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                          rand_switch(), rand_switch(),
                          16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom),
                          $urandom_range(0, 1) ? 16'($urandom)
                                               : 16'(CENTER - 8 + $urandom_range(0, 16)));
    endfunction

    // Offers one frame and holds it until the block takes it. The expected result is queued
    // at the edge where the frame is accepted. While the input side idles, tdata carries
    // junk, which the block must ignore.
    task automatic send_frame(input logic [143:0] frame, input bit typed, input decoded_t want);
        decoded_t pred;
        int       gap;
        gap = idle_len(send_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= frame;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = decode_frame(frame);
        pending_decodes.push_back(typed ? want : pred);
        frames_sent++;
    endtask

    // Writes both registers on back-to-back edges, with the write enable held high across them.
    task automatic set_config(input logic [10:0] deadband_word, input logic [10:0] limit_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEADBAND;
        cfg_data  <= deadband_word;
        @(posedge clk);
        cfg_index <= CFG_STICK_LIMIT;
        cfg_data  <= limit_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_cfg.deadband    = deadband_word[DEADBAND_W-1:0];
        model_cfg.stick_limit = limit_word;
        cfg_writes += 2;
    endtask

    // Stops offering frames and waits until the block has delivered every result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in result %0d, field %s: expected %h, got %h",
                         results_seen, name, want, got);
        end
    endtask

    // The output side stalls at random, in the same pattern of gaps as the input side.
    initial
    begin : ready_driver
        int stall;
        forever
        begin
            stall = idle_len(recv_burst);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Output monitor. Every result taken is compared, field by field, with the oldest
    // expected result.
    always @(posedge clk)
    begin
        decoded_t got;
        decoded_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = decoded_t'(m_tdata);
            results_seen++;
            if (pending_decodes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result %0d: %h", results_seen, m_tdata);
            end
            else
            begin
                want = pending_decodes.pop_front();
                check_field("stick_one", 16'(want.stick_one), 16'(got.stick_one));
                check_field("stick_two", 16'(want.stick_two), 16'(got.stick_two));
                check_field("stick_three", 16'(want.stick_three), 16'(got.stick_three));
                check_field("stick_four", 16'(want.stick_four), 16'(got.stick_four));
                check_field("switch_positions", 16'(want.switch_positions),
                            16'(got.switch_positions));
                check_field("switch_flags", 16'(want.switch_flags),
                            16'(got.switch_flags));
                check_field("mouse_x", want.mouse_x, got.mouse_x);
                check_field("mouse_y", want.mouse_y, got.mouse_y);
                check_field("mouse_z", want.mouse_z, got.mouse_z);
                check_field("mouse_buttons", want.mouse_buttons, got.mouse_buttons);
                check_field("key_bitmap", want.key_bitmap, got.key_bitmap);
                check_field("wheel", want.wheel, got.wheel);
                check_field("pad", 16'(want.pad), 16'(got.pad));
            end
        end
    end

    initial
    begin : stimulus
        logic [10:0] phase_deadband [PHASES];
        logic [10:0] phase_limit [PHASES];
        decoded_t    w;
        // The phases cover no deadband with the widest limit, the widest deadband, a zero
        // limit, a deadband above the limit, a deadband write with bit 10 set (the block
        // keeps the low ten bits), a limit beyond its stated range, two random settings,
        // and finally the reset values again.
        phase_deadband = '{11'd0, 11'h7FF, 11'd0, 11'h3FF, 11'h6BC, 11'd5, 11'd0, 11'd0, 11'd5};
        phase_limit    = '{11'd1024, 11'd1024, 11'd0, 11'd0, 11'd300, 11'd2047,
                           11'd0, 11'd0, 11'd660};
        phase_deadband[6] = 11'($urandom);
        phase_limit[6]    = 11'($urandom);
        phase_deadband[7] = 11'($urandom);
        phase_limit[7]    = 11'($urandom_range(0, 1100));

        model_cfg   = '{deadband: DEADBAND_RESET, stick_limit: STICK_LIMIT_RESET};
        last_sw_one = SW_NONE;
        last_sw_two = SW_NONE;

        // Directed frames. They run with the reset values of the registers (deadband 5,
        // limit 660).
        // An all-zero frame puts every channel at -1024, so the frame is invalid. The wheel
        // value is -1024.
        w = '0;
        w.wheel = 16'hFC00;
        directed_rows.push_back('{144'd0, 1'b1, w});
        // A centred frame with a centred wheel decodes to all zeros.
        w = '0;
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_NONE, SW_NONE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'(CENTER)), 1'b1, w});
        // An all-ones frame has every channel at +1023, so it is invalid. The mouse, button
        // and key words still pass through.
        w = '0;
        w.mouse_x       = 16'hFFFF;
        w.mouse_y       = 16'hFFFF;
        w.mouse_z       = 16'hFFFF;
        w.mouse_buttons = 16'hFFFF;
        w.key_bitmap    = 16'hFFFF;
        w.wheel         = 16'hFBFF;
        directed_rows.push_back('{{144{1'b1}}, 1'b1, w});
        // Both switches at mid after an invalid frame: a position flag but no transition.
        w = '0;
        w.switch_positions = {SW_MID, SW_MID};
        w.switch_flags[FLAG_MID] = 1'b1;
        w.switch_flags[SW_FLAGS_W+FLAG_MID] = 1'b1;
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_MID, SW_MID, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'(CENTER)), 1'b1, w});
        // Walk the switches through every transition. Then drop them to code 0, and return
        // from code 0 without a transition flag.
        w = '0;
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_UP, SW_DOWN, 16'h1, 16'h2, 16'h3, 16'h4, 16'h5,
            16'(CENTER)), 1'b0, w});
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_MID, SW_MID, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'(CENTER)), 1'b0, w});
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_DOWN, SW_UP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'(CENTER)), 1'b0, w});
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_MID, SW_MID, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'(CENTER)), 1'b0, w});
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_NONE, SW_NONE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'(CENTER)), 1'b0, w});
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_MID, SW_UP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'(CENTER)), 1'b0, w});
        // Deadband edges: plus and minus 5 become zero, plus and minus 6 pass through.
        directed_rows.push_back('{make_frame(11'(CENTER + 5), 11'(CENTER - 5),
            11'(CENTER + 6), 11'(CENTER - 6), SW_UP, SW_MID, 16'h0, 16'h0, 16'h0,
            16'h0, 16'h0, 16'(CENTER)), 1'b0, w});
        // Channels at or one step from the centre, within the deadband.
        directed_rows.push_back('{make_frame(11'(CENTER + 1), 11'(CENTER - 1),
            11'(CENTER), 11'(CENTER + 1), SW_NONE, SW_MID, 16'h0, 16'h0, 16'h0,
            16'h0, 16'h0, 16'(CENTER)), 1'b0, w});
        // Limit edges: magnitude 660 is still valid, 661 on the first or fourth channel is not.
        directed_rows.push_back('{make_frame(11'(CENTER + 660), 11'(CENTER - 660),
            11'(CENTER + 659), 11'(CENTER - 659), SW_DOWN, SW_DOWN, 16'h0, 16'h0,
            16'h0, 16'h0, 16'h0, 16'(CENTER)), 1'b0, w});
        directed_rows.push_back('{make_frame(11'(CENTER + 661), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_MID, SW_MID, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
            16'h0F0F, 16'h0000), 1'b0, w});
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER - 661), SW_MID, SW_MID, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'(CENTER)), 1'b0, w});
        directed_rows.push_back('{make_frame(11'(CENTER), 11'h7FF, 11'(CENTER),
            11'(CENTER), SW_UP, SW_UP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'(CENTER)), 1'b0, w});
        // Extremes of the mouse, button, key and wheel words. The wheel value wraps
        // around 16 bits.
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_MID, SW_MID, 16'h8000, 16'h7FFF, 16'h0001, 16'h00FF,
            16'hFF00, 16'h0000), 1'b0, w});
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_UP, SW_DOWN, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFF00,
            16'h00FF, 16'(CENTER - 1)), 1'b0, w});
        directed_rows.push_back('{make_frame(11'(CENTER), 11'(CENTER), 11'(CENTER),
            11'(CENTER), SW_MID, SW_MID, 16'h0000, 16'h0001, 16'h8000, 16'h8001,
            16'h8001, 16'hFFFF), 1'b0, w});
        directed_rows.push_back('{{$urandom, $urandom, $urandom, $urandom, 16'($urandom)},
            1'b0, w});
        directed_rows.push_back('{{$urandom, $urandom, $urandom, $urandom, 16'($urandom)},
            1'b0, w});

        // Single reset at the start of the run.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        // Random frames. Each setting of the registers is written while the block is idle.
        for (int p = 0; p < PHASES; p++)
        begin
            set_config(phase_deadband[p], phase_limit[p]);
            repeat (PHASE_ITEMS)
                send_frame(rand_frame(), 1'b0, '0);
            drain_results();
        end

        if (pending_decodes.size() != 0)
        begin
            mismatches += pending_decodes.size();
            $display("%0d expected results never arrived", pending_decodes.size());
        end
        $display("summary: %0d frames over %0d register settings, %0d of them invalid",
                 frames_sent, PHASES + 1, invalid_frames);
        $display("summary: %0d results checked, %0d switch transitions, %0d register writes",
                 results_seen, transitions, cfg_writes);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Guards against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_decodes.size());
        $display("tb: failure");
        $finish;
    end

endmodule
